// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// An implication checked on every rising clock edge outside of reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// File: sv/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Shared constants and types of the delta row compressor.
// ----------------------------------------------------------------------------
`default_nettype none

package drc_pkg;

   // Previous row store geometry.
   localparam int ROW_DEPTH  = 8192;
   localparam int ROW_ADDR_W = $clog2(ROW_DEPTH);

   // Compressed length counter.
   localparam int LEN_W = 14;
   localparam logic [LEN_W-1:0] LENGTH_MAX = '1;

   // Width for comparing a length against a raw row length.
   localparam int CMP_W = (ROW_ADDR_W + 1 > LEN_W) ? ROW_ADDR_W + 1 : LEN_W;

   // Skip counter; a run of this many unchanged bytes forces a burst.
   localparam int SKIP_W = 5;
   localparam logic [SKIP_W-1:0] FORCED_SKIP = 5'd30;

   // Burst geometry.
   localparam int BURST_MAX = 8;
   localparam int IDX_W     = 3;
   localparam int FILL_W    = 4;

   // Result item kinds.
   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_SUM  = 2'd2;

   // Work handed from the compare stage to the emitter.
   typedef struct packed {
      logic             valid;
      logic             has_burst;
      logic [IDX_W-1:0] last_idx;
      logic [7:0]       cmd;
      logic             bank;
      logic             has_sum;
      logic [LEN_W-1:0] sum_len;
      logic             ident;
      logic             notsmall;
   } job_type;

   // Write of one gathered byte into the burst buffer.
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] idx;
      logic [7:0]       data;
   } burst_wr_type;

endpackage

`default_nettype wire

// File: sv/drc_req_if.sv
// ----------------------------------------------------------------------------
// drc_req_if
// Input channel: one raster row byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface drc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_byte;
   logic       row_end;

   modport source (output valid, output row_byte, output row_end, input ready);
   modport sink   (input valid, input row_byte, input row_end, output ready);
endinterface

`default_nettype wire

// File: sv/drc_rsp_if.sv
// ----------------------------------------------------------------------------
// drc_rsp_if
// Result channel: command bytes, data bytes and row summaries.
// ----------------------------------------------------------------------------
`default_nettype none

interface drc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  item_kind;
   logic [7:0]  out_byte;
   logic [13:0] delta_length;
   logic        row_identical;
   logic        delta_not_smaller;
   logic        last_result;

   modport source (output valid, output item_kind, output out_byte,
                   output delta_length, output row_identical,
                   output delta_not_smaller, output last_result, input ready);
   modport sink   (input valid, input item_kind, input out_byte,
                   input delta_length, input row_identical,
                   input delta_not_smaller, input last_result, output ready);
endinterface

`default_nettype wire

// File: sv/delta_row_compressor.sv
// A word is registered in the compare stage; its results pass the emitter's job
// register and output word. Throughput: one word per cycle while the input is
// ready; a word with results keeps the output sequencer busy until its last
// result is loaded, and a later word with results waits in the compare stage,
// holding the input, until it is free. Reset: synchronous; a clearing pass of
// the 8192-entry previous row memory follows; no word is accepted until it ends.
// ----------------------------------------------------------------------------
// delta_row_compressor
// Compares each row byte with the previous row held in memory, gathers changed
// and forced bytes into bursts and emits command, data and summary words.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_row_compressor (
   input  wire logic  clock,
   input  wire logic  reset,
   drc_req_if.sink    req_ch,
   drc_rsp_if.source  rsp_ch
);

   logic                              accept;
   logic                              st_ready;
   logic [7:0]                        prev_byte;
   logic [drc_pkg::ROW_ADDR_W-1:0]    pos_ff;

   // Compare stage registers.
   logic                              s1_valid_ff;
   logic [7:0]                        s1_byte_ff;
   logic                              s1_last_ff;
   logic [drc_pkg::ROW_ADDR_W-1:0]    s1_pos_ff;

   // Row state.
   logic [drc_pkg::FILL_W-1:0]        fill_ff;
   logic [drc_pkg::SKIP_W-1:0]        skip_ff;
   logic [drc_pkg::LEN_W-1:0]         len_ff;
   logic                              differs_ff;
   logic                              bank_ff;

   // Compare stage logic.
   logic                              differ;
   logic                              rowdiff_new;
   logic                              want;
   logic [drc_pkg::FILL_W-1:0]        want_fill;
   logic                              flush;
   logic [drc_pkg::FILL_W-1:0]        flush_fill;
   logic [drc_pkg::LEN_W:0]           len_sum;
   logic [drc_pkg::LEN_W-1:0]         len_flush;
   logic [drc_pkg::LEN_W-1:0]         len_after;
   logic [drc_pkg::LEN_W-1:0]         sum_len;
   logic [drc_pkg::SKIP_W-1:0]        skip_base;
   logic [drc_pkg::SKIP_W-1:0]        skip_inc;
   logic                              has_results;
   logic                              em_idle;
   logic                              s1_commit;
   drc_pkg::job_type                  job;
   drc_pkg::burst_wr_type             burst_wr;

   assign s1_commit    = s1_valid_ff && (!has_results || em_idle);
   assign req_ch.ready = st_ready && (!s1_valid_ff || s1_commit);
   assign accept       = req_ch.valid && req_ch.ready;

   drc_row_store u_row_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (prev_byte),
      .wr_en   (s1_commit),
      .wr_addr (s1_pos_ff),
      .wr_data (s1_byte_ff),
      .ready   (st_ready)
   );

   // Accept stage: row position tracking and hand-off to the compare stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            if (req_ch.row_end) begin
               pos_ff <= '0;
            end else if (pos_ff != drc_pkg::ROW_ADDR_W'(drc_pkg::ROW_DEPTH - 1)) begin
               pos_ff <= pos_ff + 1'b1;
            end
         end else if (s1_commit) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_ch.row_byte;
         s1_last_ff <= req_ch.row_end;
         s1_pos_ff  <= pos_ff;
      end
   end

   // Gather decision and burst close.
   always_comb begin
      differ      = (prev_byte != s1_byte_ff);
      rowdiff_new = differs_ff || differ;
      want        = (s1_pos_ff == '0) || (skip_ff == drc_pkg::FORCED_SKIP) || differ ||
                    ((fill_ff != '0) && s1_last_ff);
      want_fill   = (fill_ff < drc_pkg::FILL_W'(drc_pkg::BURST_MAX)) ?
                    fill_ff + 1'b1 : fill_ff;
      if (want) begin
         flush      = (want_fill == drc_pkg::FILL_W'(drc_pkg::BURST_MAX)) || s1_last_ff;
         flush_fill = want_fill;
      end else begin
         flush      = (fill_ff != '0);
         flush_fill = fill_ff;
      end
      has_results = flush || s1_last_ff;
   end

   // Length bookkeeping (one command byte plus the data bytes, saturating) and skip count update.
   always_comb begin
      len_sum   = {1'b0, len_ff} + (drc_pkg::LEN_W+1)'(flush_fill) +
                  (drc_pkg::LEN_W+1)'(1);
      len_flush = (len_sum > {1'b0, drc_pkg::LENGTH_MAX}) ?
                  drc_pkg::LENGTH_MAX : len_sum[drc_pkg::LEN_W-1:0];
      len_after = flush ? len_flush : len_ff;
      sum_len   = rowdiff_new ? len_after : '0;
      skip_base = flush ? '0 : skip_ff;
      skip_inc  = (skip_base < drc_pkg::FORCED_SKIP) ? skip_base + 1'b1 : skip_base;
   end

   // Work for the emitter and the burst buffer write.
   always_comb begin
      job.valid     = s1_commit && has_results;
      job.has_burst = flush;
      job.last_idx  = drc_pkg::IDX_W'(flush_fill - 1'b1);
      job.cmd       = {drc_pkg::IDX_W'(flush_fill - 1'b1), skip_ff};
      job.bank      = bank_ff;
      job.has_sum   = s1_last_ff;
      job.sum_len   = sum_len;
      job.ident     = !rowdiff_new;
      job.notsmall  = (drc_pkg::CMP_W'(sum_len) >=
                       drc_pkg::CMP_W'(s1_pos_ff) + drc_pkg::CMP_W'(1));

      burst_wr.en   = s1_commit && want && (fill_ff < drc_pkg::FILL_W'(drc_pkg::BURST_MAX));
      burst_wr.bank = bank_ff;
      burst_wr.idx  = drc_pkg::IDX_W'(fill_ff);
      burst_wr.data = s1_byte_ff;
   end

   // Row state update on commit.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         skip_ff    <= '0;
         len_ff     <= '0;
         differs_ff <= 1'b0;
         bank_ff    <= 1'b0;
      end else if (s1_commit) begin
         if (flush) begin
            bank_ff <= !bank_ff;
         end
         if (s1_last_ff) begin
            fill_ff    <= '0;
            skip_ff    <= '0;
            len_ff     <= '0;
            differs_ff <= 1'b0;
         end else begin
            len_ff     <= len_after;
            differs_ff <= rowdiff_new;
            if (want) begin
               fill_ff <= flush ? '0 : want_fill;
               skip_ff <= flush ? '0 : skip_ff;
            end else begin
               fill_ff <= '0;
               skip_ff <= skip_inc;
            end
         end
      end
   end

   drc_emitter u_emitter (
      .clock    (clock),
      .reset    (reset),
      .job      (job),
      .burst_wr (burst_wr),
      .idle     (em_idle),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

// File: sv/drc_row_store.sv
// ----------------------------------------------------------------------------
// drc_row_store
// Previous row memory with one read and one write port, a clearing pass after
// reset and a bypass for a read and a write to the same entry in one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_row_store (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rd_en,
   input  wire logic [drc_pkg::ROW_ADDR_W-1:0]  rd_addr,
   output logic [7:0]                           rd_data,
   input  wire logic                            wr_en,
   input  wire logic [drc_pkg::ROW_ADDR_W-1:0]  wr_addr,
   input  wire logic [7:0]                      wr_data,
   output logic                                 ready
);

   logic [7:0]                       row_mem [drc_pkg::ROW_DEPTH];
   logic [7:0]                       rd_q_ff;
   logic                             byp_ff;
   logic [7:0]                       byp_data_ff;
   logic                             clearing_ff;
   logic [drc_pkg::ROW_ADDR_W-1:0]   clr_addr_ff;

   // Clearing pass: one entry per cycle after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == drc_pkg::ROW_ADDR_W'(drc_pkg::ROW_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         row_mem[clr_addr_ff] <= 8'd0;
      end else if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, with the written byte captured when addresses collide.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff     <= row_mem[rd_addr];
         byp_ff      <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_q_ff;
   assign ready   = !clearing_ff;

endmodule

`default_nettype wire

// File: sv/drc_emitter.sv
// ----------------------------------------------------------------------------
// drc_emitter
// Double-banked burst buffer and the sequencer that sends a command word with
// the burst data words, the row summary, or both, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module drc_emitter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire drc_pkg::job_type      job,
   input  wire drc_pkg::burst_wr_type burst_wr,
   output logic                       idle,
   drc_rsp_if.source                  rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD,
      ST_DATA,
      ST_SUM
   } state_type;

   state_type                     state_ff;
   logic [7:0]                    burst_mem_ff [2*drc_pkg::BURST_MAX];
   logic [drc_pkg::IDX_W-1:0]     idx_ff;
   drc_pkg::job_type              job_ff;
   logic                          rsp_valid_ff;
   logic [1:0]                    kind_ff;
   logic [7:0]                    byte_ff;
   logic [drc_pkg::LEN_W-1:0]     len_ff;
   logic                          ident_ff;
   logic                          notsmall_ff;
   logic                          last_ff;
   logic                          emit_ok;
   logic                          data_done;

   // Burst buffer: the compare stage fills one bank while the other drains.
   always_ff @(posedge clock) begin
      if (burst_wr.en) begin
         burst_mem_ff[{burst_wr.bank, burst_wr.idx}] <= burst_wr.data;
      end
   end

   assign emit_ok   = !rsp_valid_ff || rsp_ch.ready;
   assign data_done = (idx_ff == job_ff.last_idx);

   // Sequencer with its registered output word. A busy state either loads a
   // new word or, when the output is stalled, keeps the current one.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b0;
               end
               if (job.valid) begin
                  job_ff   <= job;
                  state_ff <= job.has_burst ? ST_CMD : ST_SUM;
               end
            end
            ST_CMD: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  kind_ff      <= drc_pkg::KIND_CMD;
                  byte_ff      <= job_ff.cmd;
                  len_ff       <= '0;
                  ident_ff     <= 1'b0;
                  notsmall_ff  <= 1'b0;
                  last_ff      <= 1'b0;
                  idx_ff       <= '0;
                  state_ff     <= ST_DATA;
               end
            end
            ST_DATA: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  kind_ff      <= drc_pkg::KIND_DATA;
                  byte_ff      <= burst_mem_ff[{job_ff.bank, idx_ff}];
                  len_ff       <= '0;
                  ident_ff     <= 1'b0;
                  notsmall_ff  <= 1'b0;
                  last_ff      <= data_done && !job_ff.has_sum;
                  idx_ff       <= idx_ff + 1'b1;
                  if (data_done) begin
                     state_ff <= job_ff.has_sum ? ST_SUM : ST_IDLE;
                  end
               end
            end
            ST_SUM: begin
               if (emit_ok) begin
                  rsp_valid_ff <= 1'b1;
                  kind_ff      <= drc_pkg::KIND_SUM;
                  byte_ff      <= 8'd0;
                  len_ff       <= job_ff.sum_len;
                  ident_ff     <= job_ff.ident;
                  notsmall_ff  <= job_ff.notsmall;
                  last_ff      <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle = (state_ff == ST_IDLE);

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.item_kind         = kind_ff;
   assign rsp_ch.out_byte          = byte_ff;
   assign rsp_ch.delta_length      = len_ff;
   assign rsp_ch.row_identical     = ident_ff;
   assign rsp_ch.delta_not_smaller = notsmall_ff;
   assign rsp_ch.last_result       = last_ff;

endmodule

`default_nettype wire

// File: sv/drc_checker.sv
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks of the result stream of the delta row compressor.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module drc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_item_kind,
   input wire logic [13:0] rsp_delta_length,
   input wire logic        rsp_row_identical,
   input wire logic        rsp_delta_not_smaller,
   input wire logic        rsp_last_result
);

   logic rsp_fire;
   logic req_fire;

   assign rsp_fire = rsp_valid && rsp_ready;
   assign req_fire = req_valid && req_ready;

   // A stalled result word stays offered.
   `ASSERT_IMPL(a_rsp_hold, rsp_valid && !rsp_ready, ##1 rsp_valid, "result word dropped while stalled")

   // Every row summary ends the results of its input word.
   `ASSERT_IMPL(a_sum_last, rsp_fire && (rsp_item_kind == drc_pkg::KIND_SUM), rsp_last_result, "summary not marked last")

   // A command byte is never the last result of its input word.
   `ASSERT_IMPL(a_cmd_not_last, rsp_fire && (rsp_item_kind == drc_pkg::KIND_CMD), !rsp_last_result, "command marked last")

   // Summary fields stay clear outside of summaries.
   `ASSERT_IMPL(a_plain_fields, rsp_fire && (rsp_item_kind != drc_pkg::KIND_SUM), (rsp_delta_length == 14'd0) && !rsp_row_identical && !rsp_delta_not_smaller, "summary fields set on a byte word")

   // An identical row reports zero length, and only in a summary.
   `ASSERT_IMPL(a_ident_len, rsp_fire && rsp_row_identical, (rsp_delta_length == 14'd0) && (rsp_item_kind == drc_pkg::KIND_SUM) && (req_fire || !req_fire), "identical row with nonzero length")

endmodule

bind delta_row_compressor drc_checker u_drc_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_valid             (req_ch.valid),
   .req_ready             (req_ch.ready),
   .rsp_valid             (rsp_ch.valid),
   .rsp_ready             (rsp_ch.ready),
   .rsp_item_kind         (rsp_ch.item_kind),
   .rsp_delta_length      (rsp_ch.delta_length),
   .rsp_row_identical     (rsp_ch.row_identical),
   .rsp_delta_not_smaller (rsp_ch.delta_not_smaller),
   .rsp_last_result       (rsp_ch.last_result)
);

`default_nettype wire
